// ----- design/cicsd_pkg.sv -----
package cicsd_pkg;

  localparam int unsigned PcmW        = 16;
  localparam int unsigned CombW       = 19;  // three differences grow 16 -> 19 bits
  localparam int unsigned IntegW      = 32;
  localparam int unsigned IntegShift  = 20;
  localparam int unsigned LevelW      = IntegW - IntegShift;
  localparam int unsigned SdmW        = 16;
  localparam int unsigned LevelOffset = 128;
  localparam int unsigned FeedbackSh  = 8;
  localparam int unsigned UpsampleDef = 64;

  localparam logic [1:0] SDM_ORD_THRESH = 2'd0;
  localparam logic [1:0] SDM_ORD_FIRST  = 2'd1;
  localparam logic [1:0] SDM_ORD_SECOND = 2'd2;
  localparam logic [1:0] SDM_ORD_RESET  = SDM_ORD_FIRST;

  // head of the queue between comb and integrator/modulator
  typedef struct packed {
    logic                    vld;
    logic signed [CombW-1:0] diff;
  } q_head_t;

endpackage

// ----- design/cicsd_comb.sv -----
module cicsd_comb
  import cicsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic signed [PcmW-1:0]  pcm_sample_i,
  input  logic                    q_full_i,
  output logic                    in_stall_o,
  output logic                    push_o,
  output logic signed [CombW-1:0] push_data_o
);

  logic signed [PcmW-1:0]    dly_a_q;
  logic signed [PcmW:0]      dly_b_q;
  logic signed [PcmW+1:0]    dly_c_q;
  logic signed [PcmW:0]      d1;
  logic signed [PcmW+1:0]    d2;
  logic signed [PcmW+2:0]    d3;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    d1 = (PcmW+1)'(pcm_sample_i) - (PcmW+1)'(dly_a_q);
    d2 = (PcmW+2)'(d1) - (PcmW+2)'(dly_b_q);
    d3 = (PcmW+3)'(d2) - (PcmW+3)'(dly_c_q);
  end

  assign push_data_o = CombW'(d3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_a_q <= '0;
      dly_b_q <= '0;
      dly_c_q <= '0;
    end else if (push_o) begin
      dly_a_q <= pcm_sample_i;
      dly_b_q <= d1;
      dly_c_q <= d2;
    end
  end

endmodule

// ----- design/cicsd_fifo.sv -----
module cicsd_fifo
  import cicsd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic signed [CombW-1:0] data_i,
  input  logic                    pop_i,
  output q_head_t                 head_o,
  output logic                    full_o
);

  logic signed [CombW-1:0] mem_q [2];
  logic                    wr_ptr_q, rd_ptr_q;
  logic [1:0]              cnt_q;

  assign full_o      = cnt_q[1];
  assign head_o.vld  = (cnt_q != 2'd0);
  assign head_o.diff = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- design/cicsd_back.sv -----
module cicsd_back
  import cicsd_pkg::*;
#(
  parameter int unsigned UPSAMPLE_RATE = UpsampleDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_head_t    head_i,
  output logic       pop_o,
  input  logic [1:0] sdm_order_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       speaker_bit_o,
  output logic       last_in_run_o
);

  localparam int unsigned CntW = (UPSAMPLE_RATE > 1) ? $clog2(UPSAMPLE_RATE) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(UPSAMPLE_RATE - 1);

  logic [CntW-1:0]    cnt_q;
  logic [IntegW-1:0]  integ_a_q, integ_b_q, integ_c_q;
  logic               s1_vld_q, s2_vld_q, s3_vld_q;
  logic               s1_last_q, s2_last_q, s3_last_q;
  logic [SdmW-1:0]    acc1_q, acc2_q;
  logic               out_vld_q, out_bit_q, out_last_q;

  logic               adv, issue, step_last;
  logic [IntegW-1:0]  feed;
  logic [SdmW-1:0]    level, acc1_ld, fb, acc2_d, v2, acc1_d;
  logic               ybit;

  // whole pipe moves together; output register empties or is taken
  assign adv       = ~out_vld_q | ~out_stall_i;
  assign issue     = adv & head_i.vld;
  assign step_last = (cnt_q == CntLast);
  assign pop_o     = issue & step_last;
  assign feed      = (cnt_q == '0) ? IntegW'(head_i.diff) : '0;

  always_comb begin
    level   = SdmW'($signed(integ_c_q[IntegW-1:IntegShift])) + SdmW'(LevelOffset);
    acc1_ld = (sdm_order_i == SDM_ORD_THRESH) ? level : acc1_q;
    ybit    = ~acc1_ld[SdmW-1];
    fb      = ybit ? SdmW'(1 << FeedbackSh) : '0;
    acc2_d  = acc2_q + level - fb;
    v2      = sdm_order_i[1] ? acc2_d : level;  // codes 2 and 3: second order
    acc1_d  = acc1_ld + v2 - fb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      integ_a_q  <= '0;
      integ_b_q  <= '0;
      integ_c_q  <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      s3_vld_q   <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_last_q  <= 1'b0;
      acc1_q     <= '0;
      acc2_q     <= '0;
      out_vld_q  <= 1'b0;
      out_bit_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= issue;
      s1_last_q <= step_last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      s3_vld_q  <= s2_vld_q;
      s3_last_q <= s2_last_q;
      out_vld_q <= s3_vld_q;
      if (issue) begin
        cnt_q     <= step_last ? '0 : cnt_q + CntW'(1);
        integ_a_q <= integ_a_q + feed;
      end
      // integrators are skewed: each stage adds the previous stage's registered sum
      if (s1_vld_q) begin
        integ_b_q <= integ_b_q + integ_a_q;
      end
      if (s2_vld_q) begin
        integ_c_q <= integ_c_q + integ_b_q;
      end
      if (s3_vld_q) begin
        out_bit_q  <= ybit;
        out_last_q <= s3_last_q;
        acc1_q     <= acc1_d;
        if (sdm_order_i[1]) begin
          acc2_q <= acc2_d;
        end
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign speaker_bit_o = out_bit_q;
  assign last_in_run_o = out_last_q;

endmodule

// ----- design/cic_interpolator_sigma_delta_dac.sv -----
// Path: queue, integrators a, b, c, then the modulator output register. Throughput:
// UPSAMPLE_RATE bits per sample, one bit per cycle while out_stall_i is low, set by
// the single integrator/modulator step unit; a two-entry queue holds pending samples.
// Reset (rst_ni low, asynchronous): comb delays, integrators and modulator sums
// clear to zero, queue and pipe empty, sdm_order returns to first order.
module cic_interpolator_sigma_delta_dac
  import cicsd_pkg::*;
#(
  parameter int unsigned UPSAMPLE_RATE = UpsampleDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PcmW-1:0] pcm_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   speaker_bit_o,
  output logic                   last_in_run_o
);

  logic [1:0]              sdm_order_q;
  logic                    push, pop, q_full;
  logic signed [CombW-1:0] push_data;
  q_head_t                 head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdm_order_q <= SDM_ORD_RESET;
    end else if (cfg_we_i) begin
      sdm_order_q <= cfg_wdata_i;
    end
  end

  cicsd_comb u_comb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .pcm_sample_i (pcm_sample_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  cicsd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .head_o (head),
    .full_o (q_full)
  );

  cicsd_back #(
    .UPSAMPLE_RATE (UPSAMPLE_RATE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .sdm_order_i   (sdm_order_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .speaker_bit_o (speaker_bit_o),
    .last_in_run_o (last_in_run_o)
  );

endmodule
